FILE: rtl/checksum_frame_receiver_core_macros.svh
// ============================================================================
// Assertion macros for the checksum frame receiver
// Shared concurrent assertion forms used by the port-level checker.
// ============================================================================
`ifndef CHECKSUM_FRAME_RECEIVER_CORE_MACROS_SVH
`define CHECKSUM_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cfr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cfr assertion failed");

`endif

FILE: rtl/cfr_pkg.sv
// ============================================================================
// cfr_pkg
// Types and constants for the checksum frame receiver.
// ============================================================================
package cfr_pkg;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] END_BYTE   = 8'h7F;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_BODY     = 2'd0;
    localparam kind_t KIND_GOOD     = 2'd1;
    localparam kind_t KIND_BADSUM   = 2'd2;
    localparam kind_t KIND_OVERFLOW = 2'd3;

    // One result item.
    typedef struct packed {
        logic [15:0] position;
        kind_t       kind;
        logic [7:0]  out_byte;
    } result_t;

endpackage

FILE: rtl/checksum_frame_receiver_core.sv
// ============================================================================
// checksum_frame_receiver_core
// Length-prefixed frame receiver with an 8-bit additive checksum.
// ============================================================================
// Usage:
// The slave channel (s_tvalid/s_tready/s_tdata) takes one received serial
// byte per transfer. A frame is 0x7E, a little-endian 16-bit body length,
// the body bytes, a checksum byte and 0x7F. Bytes outside a frame are dropped.
// The master channel returns at most one result per input transfer: each
// body byte as it arrives (kind 0), and at the end byte a good (kind 1) or
// checksum error (kind 2) report carrying the command byte and body length.
// A frame that would exceed MAX_FRAME_BYTES buffer bytes, counting start and
// end bytes, is aborted with kind 3 and the block waits for a new start byte.
// Throughput is one byte per cycle while s_tready is high: the frame state
// and the 8-bit running sum are updated in the cycle a byte is taken. A
// result is registered before it shows on m_tvalid. The output register is
// backed by a one-entry skid register, so one more result is held while a
// result is stalled; s_tready drops only while both hold results. Reset
// returns the parser to the idle phase and empties both output registers.
// ============================================================================
module checksum_frame_receiver_core
    import cfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Received byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] position
    output logic [1:0]  m_tuser    // [1:0] kind
);

    // Bytes after the start byte are counted up to MAX_FRAME_BYTES-1.
    localparam int CntW = $clog2(MAX_FRAME_BYTES);
    localparam logic [CntW-1:0] TotalLast = CntW'(MAX_FRAME_BYTES - 1);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_CHECK  = 3'd4;
    localparam logic [2:0] PH_END    = 3'd5;

    logic [2:0]      phase_reg,        phase_next;
    logic [15:0]     frame_length_reg, frame_length_next;
    logic [15:0]     body_count_reg,   body_count_next;
    logic [CntW-1:0] total_count_reg,  total_count_next;
    logic [7:0]      running_sum_reg,  running_sum_next;
    logic [7:0]      received_sum_reg, received_sum_next;
    logic [7:0]      command_byte_reg, command_byte_next;

    logic            out_valid_reg,  skid_valid_reg;
    result_t         out_data_reg,   skid_data_reg;

    logic            s_accept;
    logic            m_take;
    logic            res_valid;
    result_t         res;
    logic [15:0]     body_inc;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_take   = out_valid_reg && m_tready;
    assign body_inc = body_count_reg + 16'd1;

    // Frame parser: each step uses only compares and narrow adds.
    always_comb begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        body_count_next   = body_count_reg;
        total_count_next  = total_count_reg;
        running_sum_next  = running_sum_reg;
        received_sum_next = received_sum_reg;
        command_byte_next = command_byte_reg;
        res_valid         = 1'b0;
        res.out_byte      = command_byte_reg;
        res.kind          = KIND_BODY;
        res.position      = frame_length_reg;

        if (s_accept) begin
            if (phase_reg == PH_IDLE) begin
                if (s_tdata == START_BYTE) begin
                    phase_next        = PH_LEN_LO;
                    frame_length_next = '0;
                    body_count_next   = '0;
                    total_count_next  = '0;
                    running_sum_next  = '0;
                    received_sum_next = '0;
                    command_byte_next = '0;
                end
            end else if (total_count_reg == TotalLast) begin
                // The byte would land past the end of the buffer.
                res_valid  = 1'b1;
                res.kind   = KIND_OVERFLOW;
                phase_next = PH_IDLE;
            end else begin
                total_count_next = total_count_reg + CntW'(1);
                unique case (phase_reg)
                    PH_LEN_LO: begin
                        frame_length_next = {8'd0, s_tdata};
                        running_sum_next  = running_sum_reg + s_tdata;
                        phase_next        = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        frame_length_next = {s_tdata, frame_length_reg[7:0]};
                        running_sum_next  = running_sum_reg + s_tdata;
                        phase_next = ({s_tdata, frame_length_reg[7:0]} == 16'd0)
                                     ? PH_CHECK : PH_BODY;
                    end
                    PH_BODY: begin
                        if (body_count_reg == 16'd0) begin
                            command_byte_next = s_tdata;
                        end
                        running_sum_next = running_sum_reg + s_tdata;
                        res_valid        = 1'b1;
                        res.out_byte     = s_tdata;
                        res.kind         = KIND_BODY;
                        res.position     = body_count_reg;
                        body_count_next  = body_inc;
                        if (body_inc >= frame_length_reg) begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        received_sum_next = s_tdata;
                        phase_next        = PH_END;
                    end
                    PH_END: begin
                        // Extra bytes before the end byte are dropped.
                        if (s_tdata == END_BYTE) begin
                            res_valid  = 1'b1;
                            res.kind   = (running_sum_reg == received_sum_reg)
                                         ? KIND_GOOD : KIND_BADSUM;
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            frame_length_reg <= '0;
            body_count_reg   <= '0;
            total_count_reg  <= '0;
            running_sum_reg  <= '0;
            received_sum_reg <= '0;
            command_byte_reg <= '0;
        end else begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            body_count_reg   <= body_count_next;
            total_count_reg  <= total_count_next;
            running_sum_reg  <= running_sum_next;
            received_sum_reg <= received_sum_next;
            command_byte_reg <= command_byte_next;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= res_valid;
            end
        end else if (res_valid) begin
            if (!out_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_take) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else begin
                out_data_reg <= res;
            end
        end else if (res_valid) begin
            if (!out_valid_reg) begin
                out_data_reg <= res;
            end else begin
                skid_data_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.position, out_data_reg.out_byte};
    assign m_tuser  = out_data_reg.kind;

endmodule

FILE: rtl/cfr_checker.sv
// ============================================================================
// cfr_checker
// Port-level checks for the checksum frame receiver.
// ============================================================================
`include "checksum_frame_receiver_core_macros.svh"

module cfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result stays offered.
    `CFR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // A stalled result keeps its payload.
    `CFR_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready,
        $stable(m_tdata) && $stable(m_tuser))
    // Input back-pressure only happens when the output register is full.
    `CFR_ASSERT_NOW(a_stall_needs_out, aclk, aresetn, !s_tready, m_tvalid)
    // A drained output frees the input in the cycle after.
    `CFR_ASSERT_NEXT(a_stall_clears, aclk, aresetn, !s_tready && m_tready, s_tready)

endmodule

bind checksum_frame_receiver_core cfr_checker u_cfr_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Checksum frame receiver testbench
// Sends directed and random byte streams into the receiver. Each result is
// checked field by field against a hand-written row or an in-bench predictor.
// ============================================================================
module testbench
    import cfr_pkg::*;
();

    // Buffer size of the instance; overflow aborts depend on it.
    localparam int FRAME_BUF_BYTES = 256;
    // Cycles without any transfer on either side before the run is abandoned.
    localparam int STALL_LIMIT = 2000;
    // Cycles allowed after the last expected result for stray output.
    localparam int TAIL_CYCLES = 8;
    // The generator keeps at most this many bytes waiting ahead of the driver.
    localparam int RX_AHEAD = 8;
    localparam int DIR_ROWS = 24;

    // Parser phases of the predictor.
    typedef enum logic [2:0] {
        RX_IDLE,
        RX_LEN_LO,
        RX_LEN_HI,
        RX_BODY,
        RX_CHECK,
        RX_END
    } rx_phase_t;

    // One byte for the slave channel. When typed is set, res is the result
    // that this byte must cause, written out by hand; otherwise the predictor
    // decides what, if anything, is expected.
    typedef struct {
        logic [7:0] rx;
        bit         typed;
        result_t    res;
    } rx_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    // Predictor state, a copy of the parser's registers.
    rx_phase_t   rx_phase  = RX_IDLE;
    logic [15:0] frame_len = '0;
    logic [15:0] body_cnt  = '0;
    logic [15:0] total_cnt = '0;
    logic [7:0]  run_sum   = '0;
    logic [7:0]  rx_sum    = '0;
    logic [7:0]  cmd_byte  = '0;

    rx_item_t rx_queue[$];
    result_t  expected_results[$];
    rx_item_t cur_item;
    bit       rx_taken    = 1'b0;
    int       tx_idle_pct = 11;
    int       rx_idle_pct = 65;
    int       mismatches  = 0;
    int       quiet_cycles = 0;

    // Directed stream. Frame one carries a start byte as body data, an extra
    // byte and a second start byte after the checksum; frame two has an empty
    // body; frame three has a wrong checksum. The first three bytes arrive
    // outside any frame and must vanish.
    rx_item_t dir_table [DIR_ROWS] = '{
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h7F, 1'b0, '0},
        '{8'h7E, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b1, '{16'd0, KIND_BODY, 8'hFF}},
        '{8'h00, 1'b1, '{16'd1, KIND_BODY, 8'h00}},
        '{8'h7E, 1'b1, '{16'd2, KIND_BODY, 8'h7E}},
        '{8'h80, 1'b0, '0},
        '{8'h55, 1'b0, '0},
        '{8'h7E, 1'b0, '0},
        '{8'h7F, 1'b1, '{16'd3, KIND_GOOD, 8'hFF}},
        '{8'h7E, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h7F, 1'b1, '{16'd0, KIND_GOOD, 8'h00}},
        '{8'h7E, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hA5, 1'b1, '{16'd0, KIND_BODY, 8'hA5}},
        '{8'h00, 1'b0, '0},
        '{8'h7F, 1'b1, '{16'd1, KIND_BADSUM, 8'hA5}}
    };

    checksum_frame_receiver_core #(
        .MAX_FRAME_BYTES(FRAME_BUF_BYTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // 20 ns clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Advances the predictor by one accepted byte. Returns 1 when the byte
    // causes a result, which is then left in res.
    function automatic bit predict_frame_byte(input logic [7:0] b, output result_t res);
        res = '0;
        if (rx_phase == RX_IDLE) begin
            // Only a start byte opens a frame; everything else is line noise.
            if (b == START_BYTE) begin
                rx_phase  = RX_LEN_LO;
                frame_len = '0;
                body_cnt  = '0;
                total_cnt = '0;
                run_sum   = '0;
                rx_sum    = '0;
                cmd_byte  = '0;
            end
            return 1'b0;
        end
        // The start byte sits at buffer index 0, so this byte would land at
        // index total_cnt + 1. Past the end of the buffer the frame is dropped.
        if (int'(total_cnt) + 1 >= FRAME_BUF_BYTES) begin
            res      = '{frame_len, KIND_OVERFLOW, cmd_byte};
            rx_phase = RX_IDLE;
            return 1'b1;
        end
        total_cnt = total_cnt + 16'd1;
        case (rx_phase)
            RX_LEN_LO: begin
                frame_len = {8'h00, b};
                run_sum   = run_sum + b;
                rx_phase  = RX_LEN_HI;
            end
            RX_LEN_HI: begin
                frame_len[15:8] = b;
                run_sum         = run_sum + b;
                rx_phase        = (frame_len == 16'd0) ? RX_CHECK : RX_BODY;
            end
            RX_BODY: begin
                if (body_cnt == 16'd0) begin
                    cmd_byte = b;
                end
                run_sum  = run_sum + b;
                res      = '{body_cnt, KIND_BODY, b};
                body_cnt = body_cnt + 16'd1;
                if (body_cnt >= frame_len) begin
                    rx_phase = RX_CHECK;
                end
                return 1'b1;
            end
            RX_CHECK: begin
                rx_sum   = b;
                rx_phase = RX_END;
            end
            RX_END: begin
                // Anything but the end byte here is padding and is skipped.
                if (b == END_BYTE) begin
                    res      = '{frame_len, (run_sum == rx_sum) ? KIND_GOOD : KIND_BADSUM,
                                 cmd_byte};
                    rx_phase = RX_IDLE;
                    return 1'b1;
                end
            end
            default: begin
                rx_phase = RX_IDLE;
            end
        endcase
        return 1'b0;
    endfunction

    // Slave-side driver and receiver backpressure, both changed on the
    // falling edge. A new byte is offered only once the previous transfer has
    // completed, so s_tvalid gets a single assignment per edge.
    always @(negedge aclk) begin
        if (!s_tvalid || rx_taken) begin
            if (rx_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                cur_item = rx_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= cur_item.rx;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        rx_taken = 1'b0;
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Both channels are sampled on the rising edge, before the block's own
    // registers move. Results are checked first; the byte taken at the same
    // edge can only add an expectation behind them.
    always @(posedge aclk) begin : monitor_blk
        result_t got;
        result_t want;
        result_t predicted;
        bit      has_res;
        if (aresetn) begin
            quiet_cycles = quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                got = '{m_tdata[23:8], m_tuser, m_tdata[7:0]};
                if (expected_results.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result byte %h kind %0d pos %0d",
                                 $time, got.out_byte, got.kind, got.position);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                        got.position !== want.position) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch, expected byte %h kind %0d",
                                     $time, want.out_byte, want.kind,
                                     " pos %0d, got byte %h kind %0d pos %0d",
                                     want.position,
                                     got.out_byte, got.kind, got.position);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                quiet_cycles = 0;
                rx_taken = 1'b1;
                has_res = predict_frame_byte(s_tdata, predicted);
                // A hand-written row wins over the predictor, whose state
                // still has to follow the stream.
                if (cur_item.typed) begin
                    expected_results.push_back(cur_item.res);
                end else if (has_res) begin
                    expected_results.push_back(predicted);
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Hands one byte to the driver, keeping the lookahead short so that the
    // idle settings act on the stream as it is generated.
    task automatic queue_rx_item(input rx_item_t item);
        while (rx_queue.size() >= RX_AHEAD) begin
            @(negedge aclk);
        end
        rx_queue.push_back(item);
    endtask

    // Random frames until at least n_bytes frame bytes have been queued.
    // Most frames are well formed with short bodies; some have a bad checksum,
    // padding before the end byte, a missing end byte, a length right at the
    // buffer limit, or a declared length far past it. Line noise between
    // frames is not counted.
    task automatic queue_random_frames(input int n_bytes);
        rx_item_t   it;
        int         sent;
        int         shape;
        int         len;
        int         body_bytes;
        logic [7:0] sum;
        sent     = 0;
        it.typed = 1'b0;
        it.res   = '0;
        while (sent < n_bytes) begin
            shape = $urandom_range(99);
            if (shape < 8) begin
                repeat ($urandom_range(1, 4)) begin
                    it.rx = 8'($urandom_range(255));
                    queue_rx_item(it);
                end
            end else begin
                if (shape < 10) begin
                    len = 65535;
                end else if (shape < 15) begin
                    len = $urandom_range(256, 65534);
                end else if (shape < 23) begin
                    // Around the largest body that still fits.
                    len = $urandom_range(245, 255);
                end else begin
                    len = $urandom_range(0, 12);
                end
                // Oversized frames are cut short once the abort is certain.
                body_bytes = (len > 262) ? 262 : len;
                it.rx = START_BYTE;
                queue_rx_item(it);
                it.rx = len[7:0];
                queue_rx_item(it);
                sum = len[7:0];
                it.rx = len[15:8];
                queue_rx_item(it);
                sum = sum + len[15:8];
                for (int i = 0; i < body_bytes; i++) begin
                    it.rx = 8'($urandom_range(255));
                    sum = sum + it.rx;
                    queue_rx_item(it);
                end
                it.rx = ($urandom_range(99) < 80) ? sum : 8'($urandom_range(255));
                queue_rx_item(it);
                sent = sent + body_bytes + 4;
                if ($urandom_range(99) < 15) begin
                    repeat ($urandom_range(1, 3)) begin
                        it.rx = 8'($urandom_range(255));
                        if (it.rx == END_BYTE) begin
                            it.rx = START_BYTE;
                        end
                        queue_rx_item(it);
                        sent = sent + 1;
                    end
                end
                if ($urandom_range(99) >= 5) begin
                    it.rx = END_BYTE;
                    queue_rx_item(it);
                    sent = sent + 1;
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, with a slow-ish sender and a very stalling receiver.
        for (int r = 0; r < DIR_ROWS; r++) begin
            queue_rx_item(dir_table[r]);
        end
        queue_random_frames(600);

        // Swap: the sender idles most of the time.
        tx_idle_pct = 65;
        rx_idle_pct = 11;
        queue_random_frames(600);

        // Full rate on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random_frames(600);

        // Drain the input, then every expectation, then leave time for stray
        // results to show up.
        while (rx_queue.size() != 0 || s_tvalid) begin
            @(negedge aclk);
        end
        while (expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
